/* rtl/core/gdad_pkg.sv */
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared types, constants and calendar helpers for the date adder.
// ----------------------------------------------------------------------------
package gdad_pkg;

    localparam int YearW  = 14;
    localparam int MonthW = 4;
    localparam int DayW   = 5;
    localparam int AddW   = 16;
    localparam int TotalW = 17;
    localparam int SpanW  = 9;
    localparam int PcW    = 4;

    localparam logic [YearW-1:0]  LastYear   = YearW'(9999);
    localparam logic [YearW-1:0]  YearCycle  = YearW'(400);
    localparam logic [YearW-1:0]  CycleLast  = YearW'(399);
    localparam logic [YearW-1:0]  Century1   = YearW'(100);
    localparam logic [YearW-1:0]  Century2   = YearW'(200);
    localparam logic [YearW-1:0]  Century3   = YearW'(300);
    localparam logic [MonthW-1:0] LastMonth  = MonthW'(12);
    localparam logic [MonthW-1:0] February   = MonthW'(2);
    localparam logic [DayW-1:0]   LastDay    = DayW'(31);
    localparam logic [SpanW-1:0]  CommonYear = SpanW'(365);

    localparam logic [PcW-1:0] StepIdle      = PcW'(0);
    localparam logic [PcW-1:0] StepChkYear   = PcW'(1);
    localparam logic [PcW-1:0] StepReduce    = PcW'(2);
    localparam logic [PcW-1:0] StepChkDate   = PcW'(3);
    localparam logic [PcW-1:0] StepYears     = PcW'(4);
    localparam logic [PcW-1:0] StepYearsEnd  = PcW'(5);
    localparam logic [PcW-1:0] StepMonths    = PcW'(6);
    localparam logic [PcW-1:0] StepMonthChk  = PcW'(7);
    localparam logic [PcW-1:0] StepMonthLoop = PcW'(8);
    localparam logic [PcW-1:0] StepBad       = PcW'(9);
    localparam logic [PcW-1:0] StepOvf       = PcW'(10);
    localparam logic [PcW-1:0] StepEmit      = PcW'(11);
    localparam logic [PcW-1:0] StepDone      = PcW'(12);

    typedef enum logic [3:0] {
        OpNop,
        OpLoad,
        OpSub400,
        OpYearStep,
        OpMonthStep,
        OpSetDay,
        OpSetOvf,
        OpSetBad,
        OpEmit
    } op_t;

    typedef enum logic [3:0] {
        CondAlways,
        CondIdle,
        CondYearHigh,
        CondRemGe400,
        CondDateBad,
        CondYearFits,
        CondSpanExceeded,
        CondMonthFits,
        CondOutBlocked
    } cond_t;

    typedef struct packed {
        cond_t          cond;
        logic [PcW-1:0] target;
        op_t            op_true;
        op_t            op_false;
    } ctrl_word_t;

    typedef struct packed {
        logic year_high;
        logic rem_ge400;
        logic date_bad;
        logic year_fits;
        logic span_exceeded;
        logic month_fits;
    } status_t;

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                  input logic leap);
        logic [DayW-1:0] len;
        begin
            unique case (m)
                MonthW'(1), MonthW'(3), MonthW'(5), MonthW'(7),
                MonthW'(8), MonthW'(10), MonthW'(12): len = DayW'(31);
                MonthW'(4), MonthW'(6), MonthW'(9), MonthW'(11): len = DayW'(30);
                February: len = leap ? DayW'(29) : DayW'(28);
                default: len = DayW'(0);
            endcase
            return len;
        end
    endfunction

    function automatic logic is_leap(input logic [YearW-1:0] rem,
                                     input logic [1:0] low_bits);
        begin
            return (rem == '0) ||
                   ((low_bits == 2'd0) && (rem != Century1) &&
                    (rem != Century2) && (rem != Century3));
        end
    endfunction

endpackage

/* rtl/core/gdad_rom.sv */
// ----------------------------------------------------------------------------
// gdad_rom
// Microcode store: one control word for each step of the date program.
// ----------------------------------------------------------------------------
module gdad_rom (
    input  logic [gdad_pkg::PcW-1:0] pc,
    output gdad_pkg::ctrl_word_t     word
);

    always_comb
    begin
        word = '{gdad_pkg::CondAlways, gdad_pkg::StepIdle,
                 gdad_pkg::OpNop, gdad_pkg::OpNop};
        unique case (pc)
            gdad_pkg::StepIdle:
                word = '{gdad_pkg::CondIdle, gdad_pkg::StepIdle,
                         gdad_pkg::OpNop, gdad_pkg::OpLoad};
            gdad_pkg::StepChkYear:
                word = '{gdad_pkg::CondYearHigh, gdad_pkg::StepBad,
                         gdad_pkg::OpNop, gdad_pkg::OpNop};
            gdad_pkg::StepReduce:
                word = '{gdad_pkg::CondRemGe400, gdad_pkg::StepReduce,
                         gdad_pkg::OpSub400, gdad_pkg::OpNop};
            gdad_pkg::StepChkDate:
                word = '{gdad_pkg::CondDateBad, gdad_pkg::StepBad,
                         gdad_pkg::OpNop, gdad_pkg::OpNop};
            gdad_pkg::StepYears:
                word = '{gdad_pkg::CondYearFits, gdad_pkg::StepYears,
                         gdad_pkg::OpYearStep, gdad_pkg::OpNop};
            gdad_pkg::StepYearsEnd:
                word = '{gdad_pkg::CondSpanExceeded, gdad_pkg::StepOvf,
                         gdad_pkg::OpNop, gdad_pkg::OpNop};
            gdad_pkg::StepMonths:
                word = '{gdad_pkg::CondMonthFits, gdad_pkg::StepEmit,
                         gdad_pkg::OpSetDay, gdad_pkg::OpMonthStep};
            gdad_pkg::StepMonthChk:
                word = '{gdad_pkg::CondYearHigh, gdad_pkg::StepOvf,
                         gdad_pkg::OpNop, gdad_pkg::OpNop};
            gdad_pkg::StepMonthLoop:
                word = '{gdad_pkg::CondAlways, gdad_pkg::StepMonths,
                         gdad_pkg::OpNop, gdad_pkg::OpNop};
            gdad_pkg::StepBad:
                word = '{gdad_pkg::CondAlways, gdad_pkg::StepEmit,
                         gdad_pkg::OpSetBad, gdad_pkg::OpNop};
            gdad_pkg::StepOvf:
                word = '{gdad_pkg::CondAlways, gdad_pkg::StepEmit,
                         gdad_pkg::OpSetOvf, gdad_pkg::OpNop};
            gdad_pkg::StepEmit:
                word = '{gdad_pkg::CondOutBlocked, gdad_pkg::StepEmit,
                         gdad_pkg::OpNop, gdad_pkg::OpEmit};
            gdad_pkg::StepDone:
                word = '{gdad_pkg::CondAlways, gdad_pkg::StepIdle,
                         gdad_pkg::OpNop, gdad_pkg::OpNop};
            default:
                word = '{gdad_pkg::CondAlways, gdad_pkg::StepIdle,
                         gdad_pkg::OpNop, gdad_pkg::OpNop};
        endcase
    end

endmodule

/* rtl/core/gdad_dpath.sv */
// ----------------------------------------------------------------------------
// gdad_dpath
// Date datapath: working date, remaining day count, year-in-cycle remainder
// and the result register, driven one operation per cycle.
// ----------------------------------------------------------------------------
module gdad_dpath (
    input  logic                         clk,
    input  gdad_pkg::op_t                op,
    input  logic [gdad_pkg::YearW-1:0]   start_year,
    input  logic [gdad_pkg::MonthW-1:0]  start_month,
    input  logic [gdad_pkg::DayW-1:0]    start_day,
    input  logic [gdad_pkg::AddW-1:0]    days_to_add,
    output gdad_pkg::status_t            status,
    output logic [gdad_pkg::YearW-1:0]   end_year,
    output logic [gdad_pkg::MonthW-1:0]  end_month,
    output logic [gdad_pkg::DayW-1:0]    end_day,
    output logic                         year_overflow,
    output logic                         bad_date
);

    logic [gdad_pkg::YearW-1:0]  year_reg, year_next;
    logic [gdad_pkg::MonthW-1:0] month_reg, month_next;
    logic [gdad_pkg::DayW-1:0]   day_reg, day_next;
    logic [gdad_pkg::TotalW-1:0] total_reg, total_next;
    logic [gdad_pkg::YearW-1:0]  rem_reg, rem_next;
    logic                        ovf_reg, ovf_next;
    logic                        bad_reg, bad_next;
    logic [gdad_pkg::YearW-1:0]  end_year_reg, end_year_next;
    logic [gdad_pkg::MonthW-1:0] end_month_reg, end_month_next;
    logic [gdad_pkg::DayW-1:0]   end_day_reg, end_day_next;
    logic                        end_ovf_reg, end_ovf_next;
    logic                        end_bad_reg, end_bad_next;

    logic [gdad_pkg::YearW-1:0]  rem_inc;
    logic                        leap_now;
    logic                        leap_following;
    logic                        leap_span;
    logic [gdad_pkg::DayW-1:0]   cur_len;
    logic [gdad_pkg::SpanW-1:0]  span;
    logic                        over_span;

    always_comb
    begin
        rem_inc        = (rem_reg == gdad_pkg::CycleLast) ? '0 : rem_reg + 1'b1;
        leap_now       = gdad_pkg::is_leap(rem_reg, year_reg[1:0]);
        leap_following = gdad_pkg::is_leap(rem_inc, year_reg[1:0] + 2'd1);
        leap_span      = (month_reg <= gdad_pkg::February) ? leap_now : leap_following;
        cur_len        = gdad_pkg::month_len(month_reg, leap_now);
        span           = gdad_pkg::CommonYear + gdad_pkg::SpanW'(leap_span);
        over_span      = total_reg > gdad_pkg::TotalW'(span);

        status.year_high     = year_reg > gdad_pkg::LastYear;
        status.rem_ge400     = rem_reg >= gdad_pkg::YearCycle;
        status.date_bad      = (month_reg == '0) || (month_reg > gdad_pkg::LastMonth) ||
                               (day_reg == '0) || (day_reg > cur_len);
        status.year_fits     = over_span && (year_reg != gdad_pkg::LastYear);
        status.span_exceeded = over_span;
        status.month_fits    = total_reg <= gdad_pkg::TotalW'(cur_len);
    end

    always_comb
    begin
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        total_next     = total_reg;
        rem_next       = rem_reg;
        ovf_next       = ovf_reg;
        bad_next       = bad_reg;
        end_year_next  = end_year_reg;
        end_month_next = end_month_reg;
        end_day_next   = end_day_reg;
        end_ovf_next   = end_ovf_reg;
        end_bad_next   = end_bad_reg;
        unique case (op)
            gdad_pkg::OpNop:
            begin
            end
            gdad_pkg::OpLoad:
            begin
                year_next  = start_year;
                month_next = start_month;
                day_next   = start_day;
                total_next = gdad_pkg::TotalW'(start_day) + gdad_pkg::TotalW'(days_to_add);
                rem_next   = start_year;
                ovf_next   = 1'b0;
                bad_next   = 1'b0;
            end
            gdad_pkg::OpSub400:
            begin
                rem_next = rem_reg - gdad_pkg::YearCycle;
            end
            gdad_pkg::OpYearStep:
            begin
                total_next = total_reg - gdad_pkg::TotalW'(span);
                year_next  = year_reg + 1'b1;
                rem_next   = rem_inc;
            end
            gdad_pkg::OpMonthStep:
            begin
                total_next = total_reg - gdad_pkg::TotalW'(cur_len);
                if (month_reg == gdad_pkg::LastMonth)
                begin
                    month_next = gdad_pkg::MonthW'(1);
                    year_next  = year_reg + 1'b1;
                    rem_next   = rem_inc;
                end
                else
                begin
                    month_next = month_reg + 1'b1;
                end
            end
            gdad_pkg::OpSetDay:
            begin
                day_next = total_reg[gdad_pkg::DayW-1:0];
            end
            gdad_pkg::OpSetOvf:
            begin
                year_next  = gdad_pkg::LastYear;
                month_next = gdad_pkg::LastMonth;
                day_next   = gdad_pkg::LastDay;
                ovf_next   = 1'b1;
            end
            gdad_pkg::OpSetBad:
            begin
                bad_next = 1'b1;
            end
            gdad_pkg::OpEmit:
            begin
                end_year_next  = year_reg;
                end_month_next = month_reg;
                end_day_next   = day_reg;
                end_ovf_next   = ovf_reg;
                end_bad_next   = bad_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        year_reg      <= year_next;
        month_reg     <= month_next;
        day_reg       <= day_next;
        total_reg     <= total_next;
        rem_reg       <= rem_next;
        ovf_reg       <= ovf_next;
        bad_reg       <= bad_next;
        end_year_reg  <= end_year_next;
        end_month_reg <= end_month_next;
        end_day_reg   <= end_day_next;
        end_ovf_reg   <= end_ovf_next;
        end_bad_reg   <= end_bad_next;
    end

    assign end_year      = end_year_reg;
    assign end_month     = end_month_reg;
    assign end_day       = end_day_reg;
    assign year_overflow = end_ovf_reg;
    assign bad_date      = end_bad_reg;

endmodule

/* rtl/core/gregorian_date_add_days_top.sv */
// ----------------------------------------------------------------------------
// gregorian_date_add_days_top
// Adds a day count to a Gregorian date under a microcoded sequencer.
//
//   Channel  Direction  Handshake            Fields
//   in       input      in_valid / in_stall  start_year start_month start_day
//                                            days_to_add
//   out      output     out_valid/out_stall  end_year end_month end_day
//                                            year_overflow bad_date
//
// How long an item takes is set by the year and month step loops of the
// sequencer, one step per cycle.
// Reset returns the sequencer to its idle step and empties the result register.
// in_stall is high while an item is in work; a finished item waits in the
// result register while out_stall is high, and the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [gdad_pkg::YearW-1:0]   start_year,
    input  logic [gdad_pkg::MonthW-1:0]  start_month,
    input  logic [gdad_pkg::DayW-1:0]    start_day,
    input  logic [gdad_pkg::AddW-1:0]    days_to_add,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [gdad_pkg::YearW-1:0]   end_year,
    output logic [gdad_pkg::MonthW-1:0]  end_month,
    output logic [gdad_pkg::DayW-1:0]    end_day,
    output logic                         year_overflow,
    output logic                         bad_date
);

    logic [gdad_pkg::PcW-1:0] pc_reg, pc_next;
    logic                     out_valid_reg, out_valid_next;
    gdad_pkg::ctrl_word_t     word;
    gdad_pkg::status_t        status;
    gdad_pkg::op_t            op;
    logic                     taken;

    gdad_rom u_rom (
        .pc   (pc_reg),
        .word (word)
    );

    gdad_dpath u_dpath (
        .clk           (clk),
        .op            (op),
        .start_year    (start_year),
        .start_month   (start_month),
        .start_day     (start_day),
        .days_to_add   (days_to_add),
        .status        (status),
        .end_year      (end_year),
        .end_month     (end_month),
        .end_day       (end_day),
        .year_overflow (year_overflow),
        .bad_date      (bad_date)
    );

    always_comb
    begin
        unique case (word.cond)
            gdad_pkg::CondAlways:       taken = 1'b1;
            gdad_pkg::CondIdle:         taken = !in_valid;
            gdad_pkg::CondYearHigh:     taken = status.year_high;
            gdad_pkg::CondRemGe400:     taken = status.rem_ge400;
            gdad_pkg::CondDateBad:      taken = status.date_bad;
            gdad_pkg::CondYearFits:     taken = status.year_fits;
            gdad_pkg::CondSpanExceeded: taken = status.span_exceeded;
            gdad_pkg::CondMonthFits:    taken = status.month_fits;
            gdad_pkg::CondOutBlocked:   taken = out_valid_reg && out_stall;
            default:                    taken = 1'b1;
        endcase

        pc_next = taken ? word.target : pc_reg + 1'b1;
        op      = taken ? word.op_true : word.op_false;

        out_valid_next = out_valid_reg && out_stall;
        if (op == gdad_pkg::OpEmit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= gdad_pkg::StepIdle;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = pc_reg != gdad_pkg::StepIdle;
    assign out_valid = out_valid_reg;

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Gregorian date adder. Every accepted item is run
// through a calendar predictor in a small scoreboard, and each result that
// leaves the block is compared field by field with the oldest prediction.
// Directed dates cover leap rules, invalid dates and saturation at the last
// year; a long random run follows, with bursty idling on both channels and one
// long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic [gdad_pkg::YearW-1:0]  year;
        logic [gdad_pkg::MonthW-1:0] month;
        logic [gdad_pkg::DayW-1:0]   day;
        logic                        ovf;
        logic                        bad;
    } date_result_t;

    class date_scoreboard;
        date_result_t expected_q[$];
        int           errors;
        int           accepted;

        function new();
            errors   = 0;
            accepted = 0;
        endfunction

        function bit year_is_leap(input int unsigned y);
            return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
        endfunction

        function int unsigned days_in_month(input int unsigned y, input int unsigned m);
            int unsigned len;
            case (m)
                1, 3, 5, 7, 8, 10, 12: len = 31;
                4, 6, 9, 11:           len = 30;
                2:                     len = year_is_leap(y) ? 29 : 28;
                default:               len = 0;
            endcase
            return len;
        endfunction

        function date_result_t advance_date(input logic [gdad_pkg::YearW-1:0] y,
                                            input logic [gdad_pkg::MonthW-1:0] m,
                                            input logic [gdad_pkg::DayW-1:0] d,
                                            input logic [gdad_pkg::AddW-1:0] n);
            date_result_t r;
            int unsigned  yy;
            int unsigned  mm;
            int unsigned  total;
            r.year  = y;
            r.month = m;
            r.day   = d;
            r.ovf   = 1'b0;
            r.bad   = 1'b0;
            yy      = 32'(y);
            mm      = 32'(m);
            total   = 32'(d) + 32'(n);
            if (y > gdad_pkg::LastYear || m < 1 || m > gdad_pkg::LastMonth || d < 1 ||
                32'(d) > days_in_month(yy, mm))
            begin
                r.bad = 1'b1;
                return r;
            end
            while (!r.ovf && total > days_in_month(yy, mm))
            begin
                total = total - days_in_month(yy, mm);
                mm++;
                if (mm > gdad_pkg::LastMonth)
                begin
                    mm = 1;
                    yy++;
                    if (yy > gdad_pkg::LastYear)
                        r.ovf = 1'b1;
                end
            end
            if (r.ovf)
            begin
                r.year  = gdad_pkg::LastYear;
                r.month = gdad_pkg::LastMonth;
                r.day   = gdad_pkg::LastDay;
            end
            else
            begin
                r.year  = yy[gdad_pkg::YearW-1:0];
                r.month = mm[gdad_pkg::MonthW-1:0];
                r.day   = total[gdad_pkg::DayW-1:0];
            end
            return r;
        endfunction

        function void note_input(input logic [gdad_pkg::YearW-1:0] y,
                                 input logic [gdad_pkg::MonthW-1:0] m,
                                 input logic [gdad_pkg::DayW-1:0] d,
                                 input logic [gdad_pkg::AddW-1:0] n);
            expected_q.push_back(advance_date(y, m, d, n));
            accepted++;
        endfunction

        function void check_result(input logic [gdad_pkg::YearW-1:0] y,
                                   input logic [gdad_pkg::MonthW-1:0] m,
                                   input logic [gdad_pkg::DayW-1:0] d, input logic ovf,
                                   input logic bad);
            date_result_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result %0d-%0d-%0d with no item pending", $time, y, m, d);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (e.year !== y)
            begin
                $display("%0t: end_year expected %0d actual %0d", $time, e.year, y);
                errors++;
            end
            if (e.month !== m)
            begin
                $display("%0t: end_month expected %0d actual %0d", $time, e.month, m);
                errors++;
            end
            if (e.day !== d)
            begin
                $display("%0t: end_day expected %0d actual %0d", $time, e.day, d);
                errors++;
            end
            if (e.ovf !== ovf)
            begin
                $display("%0t: year_overflow expected %0b actual %0b", $time, e.ovf, ovf);
                errors++;
            end
            if (e.bad !== bad)
            begin
                $display("%0t: bad_date expected %0b actual %0b", $time, e.bad, bad);
                errors++;
            end
        endfunction
    endclass

    localparam int DirCount    = 24;
    localparam int RandCount   = 1726;
    localparam int QuietTail   = 150;
    localparam int HoldAt      = 500;
    localparam int HoldCycles  = 800;
    localparam int DrainCycles = 300;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [gdad_pkg::YearW-1:0]    start_year;
    logic [gdad_pkg::MonthW-1:0]   start_month;
    logic [gdad_pkg::DayW-1:0]     start_day;
    logic [gdad_pkg::AddW-1:0]     days_to_add;
    logic                          out_valid;
    logic                          out_stall;
    logic [gdad_pkg::YearW-1:0]    end_year;
    logic [gdad_pkg::MonthW-1:0]   end_month;
    logic [gdad_pkg::DayW-1:0]     end_day;
    logic                          year_overflow;
    logic                          bad_date;

    date_scoreboard sb = new();
    bit             bursts_on = 1'b1;
    bit             hold_done = 1'b0;
    int             hold_left = 0;
    int             stall_left = 0;

    int dir_y[DirCount] = '{2024, 2023, 1900, 2000, 0, 0, 0, 9999, 9999, 9999, 9998, 9998,
                            10000, 16383, 2021, 2021, 2021, 2021, 2021, 1999, 2100, 2000,
                            5000, 2400};
    int dir_m[DirCount] = '{2, 2, 2, 2, 2, 1, 1, 12, 12, 1, 12, 12,
                            1, 15, 0, 13, 4, 4, 4, 12, 2, 1,
                            6, 2};
    int dir_d[DirCount] = '{29, 29, 29, 29, 29, 1, 1, 31, 31, 1, 31, 31,
                            1, 31, 10, 1, 0, 31, 30, 31, 28, 31,
                            15, 28};
    int dir_n[DirCount] = '{0, 5, 1, 365, 1, 0, 65535, 0, 1, 65535, 365, 366,
                            5, 65535, 3, 1, 1, 1, 1, 1, 1, 29,
                            40000, 1};

    gregorian_date_add_days_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .start_year    (start_year),
        .start_month   (start_month),
        .start_day     (start_day),
        .days_to_add   (days_to_add),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .end_year      (end_year),
        .end_month     (end_month),
        .end_day       (end_day),
        .year_overflow (year_overflow),
        .bad_date      (bad_date)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #40000000;
        $display("tb: done, errors");
        $finish;
    end

    task automatic send_date(input logic [gdad_pkg::YearW-1:0] y,
                             input logic [gdad_pkg::MonthW-1:0] m,
                             input logic [gdad_pkg::DayW-1:0] d,
                             input logic [gdad_pkg::AddW-1:0] n);
        int gap;
        if (bursts_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        start_year  <= y;
        start_month <= m;
        start_day   <= d;
        days_to_add <= n;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(y, m, d, n);
    endtask

    task automatic pick_random_date(output logic [gdad_pkg::YearW-1:0] y,
                                    output logic [gdad_pkg::MonthW-1:0] m,
                                    output logic [gdad_pkg::DayW-1:0] d,
                                    output logic [gdad_pkg::AddW-1:0] n);
        int          kind;
        int          span;
        int unsigned len;
        kind = $urandom_range(0, 99);
        span = $urandom_range(0, 9);
        case ($urandom_range(0, 5))
            0:       y = gdad_pkg::YearW'($urandom_range(9800, 9999));
            1:       y = gdad_pkg::YearW'(100 * $urandom_range(0, 99) +
                                          $urandom_range(0, 1) * 4);
            default: y = gdad_pkg::YearW'($urandom_range(0, 9999));
        endcase
        m   = gdad_pkg::MonthW'($urandom_range(1, 12));
        len = sb.days_in_month(32'(y), 32'(m));
        d   = gdad_pkg::DayW'($urandom_range(1, len));
        if (span < 3)
            n = gdad_pkg::AddW'($urandom_range(0, 40));
        else if (span < 6)
            n = gdad_pkg::AddW'($urandom_range(0, 800));
        else
            n = gdad_pkg::AddW'($urandom);
        if (kind < 6)
        begin
            y = gdad_pkg::YearW'($urandom);
            m = gdad_pkg::MonthW'($urandom);
            d = gdad_pkg::DayW'($urandom);
        end
        else if (kind < 10)
            d = (len == 31) ? '0 : gdad_pkg::DayW'($urandom_range(len + 1, 31));
        else if (kind < 12)
            m = ($urandom_range(0, 1) != 0) ? '0 : gdad_pkg::MonthW'($urandom_range(13, 15));
        else if (kind < 14)
            y = gdad_pkg::YearW'($urandom_range(10000, 16383));
    endtask

    initial
    begin
        logic [gdad_pkg::YearW-1:0]  ry;
        logic [gdad_pkg::MonthW-1:0] rm;
        logic [gdad_pkg::DayW-1:0]   rd;
        logic [gdad_pkg::AddW-1:0]   rn;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        start_year  <= '0;
        start_month <= '0;
        start_day   <= '0;
        days_to_add <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DirCount; i++)
            send_date(gdad_pkg::YearW'(dir_y[i]), gdad_pkg::MonthW'(dir_m[i]),
                      gdad_pkg::DayW'(dir_d[i]), gdad_pkg::AddW'(dir_n[i]));
        for (int i = 0; i < RandCount; i++)
        begin
            bursts_on = !(((i / 100) % 4 == 3) || (i >= RandCount - QuietTail));
            pick_random_date(ry, rm, rd, rn);
            send_date(ry, rm, rd, rn);
        end
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                sb.check_result(end_year, end_month, end_day, year_overflow, bad_date);
            if (!hold_done && sb.accepted >= HoldAt)
            begin
                hold_done = 1'b1;
                hold_left = HoldCycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (bursts_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

endmodule
